// File: src/ptps_pkg.sv
// shared types, constants and the arctangent table for the panorama splat block
`default_nettype none
package ptps_pkg;

  localparam int ROWS_DEF  = 512;
  localparam int COLS_DEF  = 1024;
  localparam int STEPS_DEF = 20;

  // datapath width of the cordic vector (q32.16 plus growth headroom)
  localparam int VW = 52;
  localparam int AW = 34;

  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [AW-1:0] HALF_TURN    = 34'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [8:0] pixel_row;
    logic [9:0] pixel_col;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_word_t;

  // classified job handed from the front to the back
  typedef struct packed {
    logic        hit;
    logic [12:0] row;
    logic [13:0] col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } job_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/ptps_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ptps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read-first port, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: src/ptps_front.sv
// front end: up to two cordic vectoring passes on one unit, then cell mapping
`default_nettype none
module ptps_front #(
  parameter int ROWS  = ptps_pkg::ROWS_DEF,
  parameter int COLS  = ptps_pkg::COLS_DEF,
  parameter int STEPS = ptps_pkg::STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ptps_pkg::in_word_t in_word,
  output      logic              busy,
  output      logic              job_valid,
  output      ptps_pkg::job_t    job,
  input  wire logic              job_ready
);
  import ptps_pkg::*;

  localparam int NSTEP = (STEPS > 32) ? 32 : STEPS;
  localparam int RW = $clog2(ROWS) + 2;
  localparam int CW = $clog2(COLS) + 2;

  typedef enum logic [2:0] {S_IDLE, S_PRE, S_ITER, S_GAIN, S_MAP, S_OUT} st_t;

  st_t st_r;
  logic pass_r;
  logic [5:0] step_r;
  logic signed [VW-1:0] x_r, y_r, z_r;
  logic signed [AW-1:0] a_r, theta_r;
  logic signed [VW-1:0] m_r;
  logic [63:0] mlo_r, mhi_r;
  logic [7:0] r_r, g_r, b_r;
  logic orig_r, vert_r;
  logic signed [RW+AW:0] rowp_r;
  logic signed [CW+AW+1:0] colp_r;
  job_t job_r;

  logic signed [VW-1:0] dx, dy;
  logic signed [AW-1:0] at;
  logic [63:0] row_full;
  logic signed [CW+AW+1:0] col_full;
  logic signed [AW-1:0] phi_c;

  assign dx = y_r >>> step_r[4:0];
  assign dy = x_r >>> step_r[4:0];
  assign at = AW'(signed'({1'b0, atan_lut(step_r[4:0])}));
  assign phi_c = a_r[AW-1] ? '0 : ((a_r > HALF_TURN) ? HALF_TURN : a_r);

  assign busy = (st_r != S_IDLE);
  assign job_valid = (st_r == S_OUT);
  assign job = job_r;

  // sequencer for both cordic passes and the mapping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          x_r <= VW'(in_word.pos_x) <<< 16;
          y_r <= VW'(in_word.pos_y) <<< 16;
          z_r <= VW'(in_word.pos_z) <<< 16;
          r_r <= in_word.red_in; g_r <= in_word.green_in; b_r <= in_word.blue_in;
          orig_r <= (in_word.pos_x == 0) && (in_word.pos_y == 0) && (in_word.pos_z == 0);
          vert_r <= (in_word.pos_x == 0) && (in_word.pos_y == 0);
          pass_r <= 1'b0;
          a_r <= '0;
          st_r <= S_PRE;
        end
        S_PRE: begin
          // quarter turn for the left half-plane
          if (x_r < 0) begin
            if (y_r >= 0) begin
              x_r <= y_r; y_r <= -x_r; a_r <= QUARTER_TURN;
            end else begin
              x_r <= -y_r; y_r <= x_r; a_r <= -QUARTER_TURN;
            end
          end else a_r <= '0;
          step_r <= '0;
          if (!pass_r && vert_r) begin
            theta_r <= '0; m_r <= '0; st_r <= S_GAIN;
          end else if (NSTEP == 0) st_r <= pass_r ? S_MAP : S_GAIN;
          else st_r <= S_ITER;
        end
        S_ITER: begin
          if (y_r >= 0) begin
            x_r <= x_r + dx; y_r <= y_r - dy; a_r <= a_r + at;
          end else begin
            x_r <= x_r - dx; y_r <= y_r + dy; a_r <= a_r - at;
          end
          if (step_r == 6'(NSTEP - 1)) st_r <= pass_r ? S_MAP : S_GAIN;
          step_r <= step_r + 6'd1;
        end
        S_GAIN: begin
          if (!vert_r) begin
            theta_r <= a_r;
            m_r <= x_r;
          end
          // split multiply for gain removal, registered before the add
          mhi_r <= 64'((x_r[VW-1] || vert_r) ? 32'd0 : 32'(x_r[VW-1:32]))
                   * 64'(INV_GAIN_Q32);
          mlo_r <= 64'((x_r[VW-1] || vert_r) ? 32'd0 : x_r[31:0]) * 64'(INV_GAIN_Q32);
          pass_r <= 1'b1;
          step_r <= '0;
          st_r <= S_MAP;
        end
        S_MAP: begin
          if (!pass_r) st_r <= S_MAP;
          else if (step_r == 6'd0 && m_r != -1) begin
            // first visit after gain: load pass two
            x_r <= z_r;
            y_r <= VW'(mhi_r + (mlo_r >> 32));
            m_r <= -1;
            st_r <= S_PRE;
          end else begin
            rowp_r <= (RW+AW+1)'(phi_c) * (RW+AW+1)'(ROWS);
            colp_r <= (CW+AW+2)'(COLS) * (CW+AW+2)'(HALF_TURN)
                      - (CW+AW+2)'(theta_r) * (CW+AW+2)'(COLS);
            st_r <= S_OUT;
          end
        end
        S_OUT: if (job_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign row_full = 64'(rowp_r >>> 31);
  assign col_full = colp_r >>> 32;

  // classify hit or miss
  always_comb begin
    job_r.row = 13'(row_full);
    job_r.col = 14'(col_full);
    job_r.red = r_r; job_r.green = g_r; job_r.blue = b_r;
    job_r.hit = !orig_r && (row_full < 64'(ROWS)) && !col_full[CW+AW+1]
                && (col_full < (CW+AW+2)'(COLS));
  end

  // the result leaves only after mapping
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> busy) else $error("job without busy");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ITER) |-> (step_r < 6'(NSTEP))) else $error("step overrun");
endmodule
`default_nettype wire

// File: src/ptps_back.sv
// back end: clearing pass and pixel read-modify-write
`default_nettype none
module ptps_back #(
  parameter int ROWS = ptps_pkg::ROWS_DEF,
  parameter int COLS = ptps_pkg::COLS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  input  wire ptps_pkg::job_t     job,
  output      logic               job_ready,
  output      logic               clearing,
  output      logic               out_valid,
  output      ptps_pkg::out_word_t out_word
);
  import ptps_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int ABITS = $clog2(DEPTH);

  typedef enum logic [1:0] {B_CLR, B_IDLE, B_READ, B_WRITE} bst_t;

  bst_t st_r;
  logic [ABITS:0] clr_r;
  logic [ABITS-1:0] addr_r;
  job_t j_r;
  logic we;
  logic [ABITS-1:0] addr;
  logic [23:0] wdata, rdata, upd;

  assign job_ready = (st_r == B_IDLE);
  assign clearing = (st_r == B_CLR);

  // pick the new pixel
  always_comb begin
    if (rdata == 24'd0) upd = {j_r.red, j_r.green, j_r.blue};
    else upd = {8'((9'(rdata[23:16]) + 9'(j_r.red)) >> 1),
                8'((9'(rdata[15:8]) + 9'(j_r.green)) >> 1),
                8'((9'(rdata[7:0]) + 9'(j_r.blue)) >> 1)};
  end

  assign we = (st_r == B_CLR) || (st_r == B_WRITE);
  assign addr = (st_r == B_CLR) ? clr_r[ABITS-1:0] : addr_r;
  assign wdata = (st_r == B_CLR) ? 24'd0 : upd;

  ptps_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (ABITS+1)'(DEPTH - 1)) st_r <= B_IDLE;
        end
        B_IDLE: if (job_valid) begin
          j_r <= job;
          addr_r <= ABITS'(32'(job.row) * 32'(COLS) + 32'(job.col));
          if (job.hit) st_r <= B_READ;
          else begin
            out_valid <= 1'b1;
            out_word <= '0;
          end
        end
        B_READ: st_r <= B_WRITE;
        B_WRITE: begin
          out_valid <= 1'b1;
          out_word.hit <= 1'b1;
          out_word.pixel_row <= 9'(j_r.row);
          out_word.pixel_col <= 10'(j_r.col);
          out_word.red_out <= upd[23:16];
          out_word.green_out <= upd[15:8];
          out_word.blue_out <= upd[7:0];
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  a_noclr: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid) else $error("result while clearing");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_READ) |=> (st_r == B_WRITE)) else $error("rmw broken");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
endmodule
`default_nettype wire

// File: src/point_to_panorama_splat.sv
// top level of the point to panorama splat block
// Usage: drive in_word with a point and colour and raise start; the word is
// taken at an edge where start is high and busy is low. One result word per
// point appears on out_word for one cycle with out_valid high; it cannot be
// held off. Hit means the pixel at pixel_row/pixel_col now holds the colour
// shown; a miss gives all zeros.
// Each point takes two vectoring passes on one shared shift-add unit, gain
// and mapping multiplies and, for a hit, a read-modify-write on the single
// ram port. A point with x = y = 0 skips the first pass.
// The front and back are decoupled by a one-word handoff, so busy drops once
// the back has taken the job while it still finishes its write.
// Reset: synchronous, active low. After reset a clearing pass writes zero to
// every pixel (ROWS*COLS, 524288 by default); busy stays high then.
`default_nettype none
module point_to_panorama_splat #(
  parameter int ROWS         = ptps_pkg::ROWS_DEF,
  parameter int COLS         = ptps_pkg::COLS_DEF,
  parameter int CORDIC_STEPS = ptps_pkg::STEPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire ptps_pkg::in_word_t  in_word,
  output      logic                out_valid,
  output      ptps_pkg::out_word_t out_word
);
  import ptps_pkg::*;

  logic fbusy, jv, jr, clr;
  job_t jb;

  assign busy = fbusy || clr;

  ptps_front #(.ROWS(ROWS), .COLS(COLS), .STEPS(CORDIC_STEPS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start && !clr), .in_word(in_word),
    .busy(fbusy), .job_valid(jv), .job(jb), .job_ready(jr)
  );

  ptps_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(jv), .job(jb), .job_ready(jr),
    .clearing(clr), .out_valid(out_valid), .out_word(out_word)
  );
endmodule
`default_nettype wire

// File: tb/point_to_panorama_splat_test.sv
// self-checking testbench for the point to panorama splat block
`default_nettype none
module point_to_panorama_splat_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptps_pkg::*;

  localparam int NROWS = ROWS_DEF;
  localparam int NCOLS = COLS_DEF;
  localparam int NSTEPS = STEPS_DEF;
  localparam longint GAIN_INV = 64'h9B74EDA8;
  localparam longint QTURN = 64'sd1073741824;
  localparam longint HTURN = 64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;

  point_to_panorama_splat uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always #2 clk = ~clk;

  // binary-angle arctangent steps, 2^31 is a half turn
  longint arc_step [32] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001, 'h00000000};

  // panorama contents seen so far, absent entries are black
  logic [23:0] panorama [int];
  out_word_t pending_pixels [$];
  in_word_t point_pool [$];
  int mismatches = 0;
  int words_sent = 0;
  int hits_seen = 0;
  int misses_seen = 0;
  int blends_done = 0;

  // shift-add vectoring, returns angle and leaves the scaled magnitude in mag
  function automatic longint vector_angle(longint vx, longint vy, output longint mag);
    longint a, t, dx, dy;
    int n;
    a = 0;
    n = (NSTEPS > 32) ? 32 : NSTEPS;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; a = QTURN;
      end else begin
        vx = -vy; vy = t; a = -QTURN;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; a += arc_step[i];
      end else begin
        vx -= dx; vy += dy; a -= arc_step[i];
      end
    end
    mag = vx;
    return a;
  endfunction

  // project one point and splat it into the panorama copy
  function automatic out_word_t splat_point(in_word_t w);
    out_word_t res;
    longint px, py, pz, theta, phi, m, r, unused, row, col;
    longint unsigned um;
    logic [23:0] pix;
    logic [8:0] s;
    int idx;
    res = '0;
    px = longint'(w.pos_x) * 65536;
    py = longint'(w.pos_y) * 65536;
    pz = longint'(w.pos_z) * 65536;
    if (px == 0 && py == 0 && pz == 0) return res;
    theta = 0;
    m = 0;
    if (!(px == 0 && py == 0)) theta = vector_angle(px, py, m);
    if (m < 0) m = 0;
    um = m;
    r = longint'((um >> 32) * GAIN_INV + (((um & 64'hFFFFFFFF) * GAIN_INV) >> 32));
    phi = vector_angle(pz, r, unused);
    if (phi < 0) phi = 0;
    if (phi > HTURN) phi = HTURN;
    row = (phi * NROWS) >>> 31;
    col = (longint'(NCOLS) * HTURN - theta * NCOLS) >>> 32;
    if (row < 0 || row >= NROWS || col < 0 || col >= NCOLS) return res;
    idx = int'(row) * NCOLS + int'(col);
    pix = panorama.exists(idx) ? panorama[idx] : 24'h0;
    if (pix == 24'h0) begin
      pix = {w.red_in, w.green_in, w.blue_in};
    end else begin
      blends_done++;
      s = pix[23:16] + w.red_in;   pix[23:16] = s[8:1];
      s = pix[15:8] + w.green_in;  pix[15:8] = s[8:1];
      s = pix[7:0] + w.blue_in;    pix[7:0] = s[8:1];
    end
    panorama[idx] = pix;
    res.hit = 1'b1;
    res.pixel_row = row[8:0];
    res.pixel_col = col[9:0];
    {res.red_out, res.green_out, res.blue_out} = pix;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // hand one word over; start stays high for the caller to lower or reuse
  task automatic send_point(in_word_t w);
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_pixels = {pending_pixels, splat_point(w)};
    words_sent++;
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", out_word, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_word.hit != want.hit) report_mismatch("hit", out_word.hit, want.hit);
        if (out_word.pixel_row != want.pixel_row)
          report_mismatch("pixel_row", out_word.pixel_row, want.pixel_row);
        if (out_word.pixel_col != want.pixel_col)
          report_mismatch("pixel_col", out_word.pixel_col, want.pixel_col);
        if (out_word.red_out != want.red_out)
          report_mismatch("red_out", out_word.red_out, want.red_out);
        if (out_word.green_out != want.green_out)
          report_mismatch("green_out", out_word.green_out, want.green_out);
        if (out_word.blue_out != want.blue_out)
          report_mismatch("blue_out", out_word.blue_out, want.blue_out);
        if (want.hit) hits_seen++; else misses_seen++;
      end
    end
  end

  function automatic in_word_t make_point(int px, int py, int pz, logic [23:0] rgb);
    in_word_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    {w.red_in, w.green_in, w.blue_in} = rgb;
    return w;
  endfunction

  // origin, poles, half-planes, coordinate and colour extremes, blending
  task automatic test_directed();
    send_point(make_point(0, 0, 0, 24'hFFFFFF));
    send_point(make_point(0, 0, 65536, 24'h102030));
    send_point(make_point(0, 0, 65536, 24'hFFFFFF));
    send_point(make_point(0, 0, -65536, 24'hABCDEF));
    send_point(make_point(65536, 0, 0, 24'hFFFFFF));
    send_point(make_point(65536, 0, 0, 24'h000000));
    send_point(make_point(65536, 0, 0, 24'h000000));
    send_point(make_point(65536, 0, 0, 24'h80FF01));
    send_point(make_point(-65536, 0, 0, 24'h112233));
    send_point(make_point(-65536, -1, 0, 24'h445566));
    send_point(make_point(0, 65536, 0, 24'h778899));
    send_point(make_point(0, -65536, 0, 24'hAABBCC));
    send_point(make_point(-65536, 65536, 3, 24'h010203));
    send_point(make_point(-65536, -65536, -3, 24'hFEFDFC));
    send_point(make_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF));
    send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 24'hFFFFFF));
    send_point(make_point(32'h80000000, 0, 0, 24'h0F0F0F));
    send_point(make_point(32'h7FFFFFFF, 32'h80000000, 1, 24'hF0F0F0));
    send_point(make_point(1, 0, 0, 24'h123456));
    send_point(make_point(-1, 0, 0, 24'h654321));
    send_point(make_point(0, 1, 0, 24'hFF00FF));
    send_point(make_point(0, 0, -1, 24'h00FF00));
    start <= 1'b0;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(0, 2 * 1048576)) - 1048576;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return ($urandom_range(3) == 0) ? 0 : int'($urandom) >>> $urandom_range(20);
    endcase
  endfunction

  // mostly revisits of earlier points so pixels get blended, the rest fresh
  task automatic test_random(int count, int idle_pct);
    in_word_t w;
    for (int k = 0; k < count; k++) begin
      if (point_pool.size() > 0 && $urandom_range(99) < 55) begin
        w = point_pool[$urandom_range(point_pool.size() - 1)];
      end else begin
        w = make_point(rand_coord(), rand_coord(), rand_coord(), 24'h0);
        if (point_pool.size() < 32) point_pool = {point_pool, w};
        else point_pool[$urandom_range(31)] = w;
      end
      {w.red_in, w.green_in, w.blue_in} = ($urandom_range(9) == 0) ? 24'h0 : 24'($urandom);
      send_point(w);
      sender_gap(idle_pct);
    end
    start <= 1'b0;
  endtask

  // hold the sender off until every result is back
  task automatic test_drain_pause();
    int guard;
    guard = 0;
    while (pending_pixels.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    test_random(20, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(240, 0);
    test_random(230, 65);
    test_drain_pause();
    test_random(230, 0);
    test_random(230, 32);
    // let the last words come back, then allow for the tail latency
    for (int guard = 0; guard < 100000 && pending_pixels.size() != 0; guard++)
      @(posedge clk);
    repeat (2 * NSTEPS + 40) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch("words never returned", pending_pixels.size(), 0);
    $display("sent %0d points: %0d hits (%0d blended), %0d misses", words_sent,
             hits_seen, blends_done, misses_seen);
    $display("covered poles, origin, both half-planes, coordinate extremes, idle mixes");
    if (mismatches == 0)
      $display("point_to_panorama_splat regression: pass");
    else
      $display("point_to_panorama_splat regression: fail");
    $finish;
  end

  // run limit, clearing pass included
  initial begin
    #20000000;
    $display("point_to_panorama_splat regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/ptps_pkg.sv
src/ptps_ram.sv
src/ptps_front.sv
src/ptps_back.sv
src/point_to_panorama_splat.sv
tb/point_to_panorama_splat_test.sv
